// ----- sv/l4f_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// l4f_pkg
// Shared types and constants for the layer-4 port allow-list filter.
// ----------------------------------------------------------------------------
package l4f_pkg;

  localparam int MAX_PORT_SLOTS = 10;
  localparam int DEF_PORT_SLOTS = 10;
  localparam int DEF_QUEUE_DEPTH = 2;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_ALLOW_ACTION  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DENY_ACTION   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PORTS_FIRST   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PORTS_SECOND  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PORTS_THIRD   = 3'd4;

  localparam logic [7:0] ACT_PASS = 8'd255;
  localparam logic [7:0] ACT_DROP = 8'd2;
  localparam logic [7:0] RST_ALLOW_ACTION = 8'd255;
  localparam logic [7:0] RST_DENY_ACTION  = 8'd2;

  localparam logic [1:0] VERDICT_ALLOW = 2'd0;
  localparam logic [1:0] VERDICT_DENY  = 2'd1;
  localparam logic [1:0] VERDICT_DROP  = 2'd2;
  localparam logic [1:0] VERDICT_PASS  = 2'd3;

  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;
  localparam logic [7:0]  PROTO_TCP  = 8'd6;
  localparam logic [7:0]  PROTO_UDP  = 8'd17;

  // byte positions within the frame
  localparam logic [6:0] POS_ETYPE_HI = 7'd12;
  localparam logic [6:0] POS_ETYPE_LO = 7'd13;
  localparam logic [6:0] POS_IHL      = 7'd14;
  localparam logic [6:0] POS_PROTO6   = 7'd20;
  localparam logic [6:0] POS_PROTO4   = 7'd23;
  localparam logic [6:0] POS_L4_V6    = 7'd54;

  localparam logic [6:0] LEN_ETH_MIN  = 7'd14;
  localparam logic [6:0] LEN_IPV4_MIN = 7'd34;
  localparam logic [6:0] LEN_IPV6_MIN = 7'd54;
  localparam logic [6:0] HDR_TCP_LEN  = 7'd20;
  localparam logic [6:0] HDR_UDP_LEN  = 7'd8;
  localparam logic [6:0] COUNT_MAX    = 7'd127;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]  action;
    logic [1:0]  verdict;
    logic [15:0] source_port;
    logic [15:0] destination_port;
  } out_beat_t;

  typedef enum logic [1:0] {
    CLS_PASS,
    CLS_DROP,
    CLS_PORTS
  } cls_t;

  // one parsed frame, handed from the parser to the lookup stage
  typedef struct packed {
    cls_t        cls;
    logic [15:0] sport;
    logic [15:0] dport;
  } frame_sum_t;

endpackage

// ----- sv/l4f_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// l4f_front
// Byte-stream parser: picks header fields off the wire as they pass and
// classifies the frame on its last beat.
// ----------------------------------------------------------------------------
module l4f_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                beat_acc_i,
  input  l4f_pkg::in_beat_t   beat_i,
  output logic                push_o,
  output l4f_pkg::frame_sum_t sum_o
);

  logic [6:0]  cnt_r, cnt_nxt;
  logic [15:0] etype_r, etype_nxt;
  logic [6:0]  off4_r, off4_nxt;
  logic [7:0]  proto4_r, proto4_nxt;
  logic [7:0]  proto6_r, proto6_nxt;
  logic [15:0] sp4_r, sp4_nxt, dp4_r, dp4_nxt;
  logic [15:0] sp6_r, sp6_nxt, dp6_r, dp6_nxt;

  logic [7:0] b;
  logic [6:0] len;
  logic [6:0] rel4, rel6;
  logic       in4, in6;
  logic [6:0] off_sel, need, hdr_end;
  logic [7:0] proto_sel;
  logic [15:0] sp_sel, dp_sel;

  assign b   = beat_i.frame_byte;
  assign len = (cnt_r == l4f_pkg::COUNT_MAX) ? cnt_r : cnt_r + 7'd1;

  always_comb begin
    off4_nxt = off4_r;
    if (cnt_r == l4f_pkg::POS_IHL) begin
      off4_nxt = l4f_pkg::POS_IHL + {1'b0, b[3:0], 2'b00};
    end
  end

  // offset of this beat within the IPv4 / IPv6 port words
  assign rel4 = cnt_r - off4_nxt;
  assign in4  = (cnt_r >= off4_nxt) && (rel4 < 7'd4);
  assign rel6 = cnt_r - l4f_pkg::POS_L4_V6;
  assign in6  = (cnt_r >= l4f_pkg::POS_L4_V6) && (rel6 < 7'd4);

  always_comb begin
    etype_nxt  = etype_r;
    proto4_nxt = proto4_r;
    proto6_nxt = proto6_r;
    sp4_nxt    = sp4_r;
    dp4_nxt    = dp4_r;
    sp6_nxt    = sp6_r;
    dp6_nxt    = dp6_r;
    if (cnt_r == l4f_pkg::POS_ETYPE_HI) etype_nxt[15:8] = b;
    if (cnt_r == l4f_pkg::POS_ETYPE_LO) etype_nxt[7:0]  = b;
    if (cnt_r == l4f_pkg::POS_PROTO4)   proto4_nxt = b;
    if (cnt_r == l4f_pkg::POS_PROTO6)   proto6_nxt = b;
    if (in4) begin
      case (rel4[1:0])
        2'd0:    sp4_nxt[15:8] = b;
        2'd1:    sp4_nxt[7:0]  = b;
        2'd2:    dp4_nxt[15:8] = b;
        default: dp4_nxt[7:0]  = b;
      endcase
    end
    if (in6) begin
      case (rel6[1:0])
        2'd0:    sp6_nxt[15:8] = b;
        2'd1:    sp6_nxt[7:0]  = b;
        2'd2:    dp6_nxt[15:8] = b;
        default: dp6_nxt[7:0]  = b;
      endcase
    end
    if (beat_i.frame_end) begin
      cnt_nxt = '0;
    end else if (cnt_r == l4f_pkg::COUNT_MAX) begin
      cnt_nxt = cnt_r;
    end else begin
      cnt_nxt = cnt_r + 7'd1;
    end
  end

  // classification of the frame that ends on this beat
  always_comb begin
    off_sel   = l4f_pkg::POS_L4_V6;
    proto_sel = proto6_nxt;
    sp_sel    = sp6_nxt;
    dp_sel    = dp6_nxt;
    if (etype_nxt == l4f_pkg::ETYPE_IPV4) begin
      off_sel   = off4_nxt;
      proto_sel = proto4_nxt;
      sp_sel    = sp4_nxt;
      dp_sel    = dp4_nxt;
    end
    need    = (proto_sel == l4f_pkg::PROTO_TCP) ? l4f_pkg::HDR_TCP_LEN : l4f_pkg::HDR_UDP_LEN;
    hdr_end = off_sel + need;

    sum_o.cls   = l4f_pkg::CLS_PASS;
    sum_o.sport = '0;
    sum_o.dport = '0;
    if (len < l4f_pkg::LEN_ETH_MIN) begin
      sum_o.cls = l4f_pkg::CLS_PASS;
    end else if (etype_nxt != l4f_pkg::ETYPE_IPV4 && etype_nxt != l4f_pkg::ETYPE_IPV6) begin
      sum_o.cls = l4f_pkg::CLS_PASS;
    end else if ((etype_nxt == l4f_pkg::ETYPE_IPV4 && len < l4f_pkg::LEN_IPV4_MIN) ||
                 (etype_nxt == l4f_pkg::ETYPE_IPV6 && len < l4f_pkg::LEN_IPV6_MIN)) begin
      sum_o.cls = l4f_pkg::CLS_DROP;
    end else if (proto_sel != l4f_pkg::PROTO_TCP && proto_sel != l4f_pkg::PROTO_UDP) begin
      sum_o.cls = l4f_pkg::CLS_PASS;
    end else if (hdr_end > len) begin
      sum_o.cls = l4f_pkg::CLS_DROP;
    end else begin
      sum_o.cls   = l4f_pkg::CLS_PORTS;
      sum_o.sport = sp_sel;
      sum_o.dport = dp_sel;
    end
  end

  assign push_o = beat_acc_i && beat_i.frame_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      off4_r <= l4f_pkg::POS_IHL;
    end else if (beat_acc_i) begin
      cnt_r  <= cnt_nxt;
      off4_r <= off4_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (beat_acc_i) begin
      etype_r  <= etype_nxt;
      proto4_r <= proto4_nxt;
      proto6_r <= proto6_nxt;
      sp4_r    <= sp4_nxt;
      dp4_r    <= dp4_nxt;
      sp6_r    <= sp6_nxt;
      dp6_r    <= dp6_nxt;
    end
  end

  a_cnt_clears: assert property (@(posedge clk) disable iff (!rst_n)
    push_o |=> cnt_r == 7'd0)
    else $error("byte count not cleared after last beat");

endmodule

// ----- sv/l4f_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// l4f_queue
// Small register FIFO of parsed frame summaries between parser and lookup.
// ----------------------------------------------------------------------------
module l4f_queue #(
  parameter int DEPTH = l4f_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_i,
  input  l4f_pkg::frame_sum_t push_data_i,
  output logic                full_o,
  output logic                valid_o,
  input  logic                pop_i,
  output l4f_pkg::frame_sum_t pop_data_o
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  l4f_pkg::frame_sum_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic do_push, do_pop;

  assign full_o     = (count_r == CNT_W'(DEPTH));
  assign valid_o    = (count_r != '0);
  assign pop_data_o = mem_r[rd_ptr_r];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + CNT_W'(1);
        2'b01:   count_r <= count_r - CNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data_i;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push_i && full_o))
    else $error("push into full queue");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count out of range");

endmodule

// ----- sv/l4f_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// l4f_back
// Allow-list lookup and result register; also holds the config registers.
// ----------------------------------------------------------------------------
module l4f_back #(
  parameter int PORT_SLOTS = l4f_pkg::DEF_PORT_SLOTS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we_i,
  input  logic [l4f_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [l4f_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              sum_valid_i,
  input  l4f_pkg::frame_sum_t               sum_i,
  output logic                              sum_pop_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output l4f_pkg::out_beat_t                out_data_o
);

  logic [7:0]  allow_act_r, deny_act_r;
  logic [63:0] ports_first_r, ports_second_r;
  logic [31:0] ports_third_r;
  logic [l4f_pkg::MAX_PORT_SLOTS*16-1:0] slots;

  logic               out_valid_r;
  l4f_pkg::out_beat_t out_r, out_nxt;
  logic               listed;

  assign slots = {ports_third_r, ports_second_r, ports_first_r};

  always_comb begin
    listed = 1'b0;
    for (int s = 0; s < PORT_SLOTS; s++) begin
      if (slots[s*16 +: 16] == sum_i.sport || slots[s*16 +: 16] == sum_i.dport) begin
        listed = 1'b1;
      end
    end
  end

  always_comb begin
    out_nxt.source_port      = '0;
    out_nxt.destination_port = '0;
    case (sum_i.cls)
      l4f_pkg::CLS_PORTS: begin
        out_nxt.source_port      = sum_i.sport;
        out_nxt.destination_port = sum_i.dport;
        out_nxt.action  = listed ? allow_act_r : deny_act_r;
        out_nxt.verdict = listed ? l4f_pkg::VERDICT_ALLOW : l4f_pkg::VERDICT_DENY;
      end
      l4f_pkg::CLS_DROP: begin
        out_nxt.action  = l4f_pkg::ACT_DROP;
        out_nxt.verdict = l4f_pkg::VERDICT_DROP;
      end
      default: begin
        out_nxt.action  = l4f_pkg::ACT_PASS;
        out_nxt.verdict = l4f_pkg::VERDICT_PASS;
      end
    endcase
  end

  // take a new summary whenever the result register is free or draining
  assign sum_pop_o   = sum_valid_i && (!out_valid_r || out_ready_i);
  assign out_valid_o = out_valid_r;
  assign out_data_o  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (sum_pop_o) begin
      out_valid_r <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sum_pop_o) out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      allow_act_r    <= l4f_pkg::RST_ALLOW_ACTION;
      deny_act_r     <= l4f_pkg::RST_DENY_ACTION;
      ports_first_r  <= '0;
      ports_second_r <= '0;
      ports_third_r  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        l4f_pkg::REG_ALLOW_ACTION: allow_act_r    <= cfg_data_i[7:0];
        l4f_pkg::REG_DENY_ACTION:  deny_act_r     <= cfg_data_i[7:0];
        l4f_pkg::REG_PORTS_FIRST:  ports_first_r  <= cfg_data_i;
        l4f_pkg::REG_PORTS_SECOND: ports_second_r <= cfg_data_i;
        l4f_pkg::REG_PORTS_THIRD:  ports_third_r  <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  a_unparsed_zero_ports: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_r.verdict == l4f_pkg::VERDICT_DROP ||
                    out_r.verdict == l4f_pkg::VERDICT_PASS)
    |-> out_r.source_port == 16'd0 && out_r.destination_port == 16'd0)
    else $error("ports set on unparsed frame");

  a_pop_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    sum_pop_o |=> out_valid_r)
    else $error("summary popped without result");

endmodule

// ----- sv/l4_port_allowlist_filter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// l4_port_allowlist_filter
// Layer-4 port allow-list filter for Ethernet frames, one byte per beat.
// ----------------------------------------------------------------------------
// Frames enter on the in_ channel one byte per beat, in wire order, with
// frame_end set on the last byte. Each frame yields exactly one beat on the
// out_ channel: action, verdict and the parsed source/destination ports.
// Input throughput is one byte per cycle while the queue is not full; the
// parser picks header fields off the stream as they pass, so no header
// buffer is read back. The parser classifies a frame on its last byte and
// pushes the summary into the queue; the allow-list compare then registers
// the result, raising out_valid, once the result register is free.
// A two-entry summary queue sits between parser and lookup, so the input
// keeps flowing while a result waits. in_ready drops only when that queue
// is full, i.e. after out_ready has stayed low across several frame ends.
// Config writes on cfg_ are always accepted (cfg_ready high) and should be
// issued while no frame is in flight. Reset (rst_n low, synchronous) clears
// the byte count, the queue and the output valid, and restores the register
// defaults: allow action 255, deny action 2, all port slots 0.
// ----------------------------------------------------------------------------
module l4_port_allowlist_filter #(
  parameter int ALLOWED_PORT_SLOTS = l4f_pkg::DEF_PORT_SLOTS,
  parameter int QUEUE_DEPTH        = l4f_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  l4f_pkg::in_beat_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output l4f_pkg::out_beat_t             out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [l4f_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [l4f_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic                beat_acc;
  logic                push;
  l4f_pkg::frame_sum_t push_sum, pop_sum;
  logic                q_full, q_valid, q_pop;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign beat_acc  = in_valid && in_ready;

  l4f_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .beat_acc_i (beat_acc),
    .beat_i     (in_data),
    .push_o     (push),
    .sum_o      (push_sum)
  );

  l4f_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (push),
    .push_data_i (push_sum),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .pop_i       (q_pop),
    .pop_data_o  (pop_sum)
  );

  l4f_back #(
    .PORT_SLOTS (ALLOWED_PORT_SLOTS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we_i    (cfg_valid && cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .sum_valid_i (q_valid),
    .sum_i       (pop_sum),
    .sum_pop_o   (q_pop),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

endmodule

// ----- dv/l4_port_allowlist_filter_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// l4_port_allowlist_filter_tb
// Self-checking bench for the layer-4 port allow-list filter.
// ----------------------------------------------------------------------------
// Frames are built byte by byte (IPv4/IPv6, TCP/UDP, truncated, non-IP, long)
// and streamed with bursty valid while the result side stalls at random.
// A local frame classifier keeps its own copy of the header bytes and the
// allow-list registers and queues one expected verdict per frame; every
// result beat is compared field by field against the oldest one.
// ----------------------------------------------------------------------------
module l4_port_allowlist_filter_tb;

  localparam logic [l4f_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam logic [7:0]  PROTO_ICMP  = 8'd1;
  localparam logic [7:0]  PROTO_ICMP6 = 8'd58;
  localparam logic [15:0] ETYPE_LLDP  = 16'h88CC;
  localparam int KEPT_BYTES = 96;
  localparam int ITEMS_TARGET = 1450;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  l4f_pkg::in_beat_t              in_data = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  l4f_pkg::out_beat_t             out_data;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [l4f_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [l4f_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // classifier state
  logic [7:0]         allow_act;
  logic [7:0]         deny_act;
  logic [15:0]        slot_port [l4f_pkg::MAX_PORT_SLOTS];
  logic [7:0]         kept_hdr [KEPT_BYTES];
  int                 kept_len;
  l4f_pkg::out_beat_t verdict_q [$];
  l4f_pkg::out_beat_t head_verdict;
  int                 bad_verdicts = 0;
  int                 items_sent = 0;

  logic [7:0]  frame_buf [$];
  bit          tx_gaps = 1'b1;
  bit          rx_stalls = 1'b1;
  int          burst_left = 0;
  int          stall_left = 0;

  l4_port_allowlist_filter uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // receiver: holds out_ready low in random stall runs
  always @(posedge clk) begin
    if (!rx_stalls) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 9) < 3) begin
      stall_left = $urandom_range(0, 11);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic logic [7:0] kept_byte(input int idx);
    if (idx < KEPT_BYTES && idx < kept_len)
      return kept_hdr[idx];
    return 8'd0;
  endfunction

  function automatic bit port_allowed(input logic [15:0] port);
    for (int s = 0; s < l4f_pkg::DEF_PORT_SLOTS; s++)
      if (slot_port[s] == port)
        return 1'b1;
    return 1'b0;
  endfunction

  function automatic l4f_pkg::out_beat_t classify_frame();
    l4f_pkg::out_beat_t r;
    logic [15:0]        etype;
    logic [7:0]         proto;
    logic [7:0]         ihl_byte;
    int                 off;
    int                 need;
    r = '0;
    r.action = l4f_pkg::ACT_PASS;
    r.verdict = l4f_pkg::VERDICT_PASS;
    if (kept_len < l4f_pkg::LEN_ETH_MIN)
      return r;
    etype = {kept_byte(l4f_pkg::POS_ETYPE_HI), kept_byte(l4f_pkg::POS_ETYPE_LO)};
    if (etype == l4f_pkg::ETYPE_IPV4) begin
      if (kept_len < l4f_pkg::LEN_IPV4_MIN) begin
        r.action = l4f_pkg::ACT_DROP;
        r.verdict = l4f_pkg::VERDICT_DROP;
        return r;
      end
      proto = kept_byte(l4f_pkg::POS_PROTO4);
      ihl_byte = kept_byte(l4f_pkg::POS_IHL);
      off = l4f_pkg::POS_IHL + 4 * ihl_byte[3:0];
    end else if (etype == l4f_pkg::ETYPE_IPV6) begin
      if (kept_len < l4f_pkg::LEN_IPV6_MIN) begin
        r.action = l4f_pkg::ACT_DROP;
        r.verdict = l4f_pkg::VERDICT_DROP;
        return r;
      end
      proto = kept_byte(l4f_pkg::POS_PROTO6);
      off = l4f_pkg::POS_L4_V6;
    end else begin
      return r;
    end
    if (proto == l4f_pkg::PROTO_TCP)
      need = l4f_pkg::HDR_TCP_LEN;
    else if (proto == l4f_pkg::PROTO_UDP)
      need = l4f_pkg::HDR_UDP_LEN;
    else
      return r;
    if (off + need > kept_len) begin
      r.action = l4f_pkg::ACT_DROP;
      r.verdict = l4f_pkg::VERDICT_DROP;
      return r;
    end
    r.source_port = {kept_byte(off), kept_byte(off + 1)};
    r.destination_port = {kept_byte(off + 2), kept_byte(off + 3)};
    if (port_allowed(r.source_port) || port_allowed(r.destination_port)) begin
      r.action = allow_act;
      r.verdict = l4f_pkg::VERDICT_ALLOW;
    end else begin
      r.action = deny_act;
      r.verdict = l4f_pkg::VERDICT_DENY;
    end
    return r;
  endfunction

  // bytes needed for a complete header stack
  function automatic int full_len(input logic [15:0] etype, input logic [7:0] proto,
                                  input logic [3:0] ihl);
    int off;
    int need;
    int ip_min;
    if (etype == l4f_pkg::ETYPE_IPV6) begin
      off = l4f_pkg::POS_L4_V6;
      ip_min = l4f_pkg::LEN_IPV6_MIN;
    end else if (etype == l4f_pkg::ETYPE_IPV4) begin
      off = l4f_pkg::POS_IHL + 4 * ihl;
      ip_min = l4f_pkg::LEN_IPV4_MIN;
    end else begin
      return l4f_pkg::LEN_ETH_MIN;
    end
    if (proto == l4f_pkg::PROTO_TCP)
      need = l4f_pkg::HDR_TCP_LEN;
    else if (proto == l4f_pkg::PROTO_UDP)
      need = l4f_pkg::HDR_UDP_LEN;
    else
      need = 0;
    return (off + need > ip_min) ? off + need : ip_min;
  endfunction

  function automatic void poke(input int idx, input logic [7:0] val);
    if (idx < frame_buf.size())
      frame_buf[idx] = val;
  endfunction

  function automatic logic [15:0] rand_slot();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_port();
    case ($urandom_range(0, 9))
      0, 1, 2: return slot_port[$urandom_range(0, l4f_pkg::DEF_PORT_SLOTS - 1)];
      3: return 16'h0000;
      4: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] rand_action();
    case ($urandom_range(0, 3))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic cmp_field(input string field, input logic [15:0] want,
                           input logic [15:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %0h got %0h", $time, field, want, got);
      bad_verdicts++;
    end
  endtask

  // result side: out_ready only moves at posedge, so the negedge view is stable
  always @(negedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (verdict_q.size() == 0) begin
        $display("%0t ns: unexpected verdict beat, expected none, got %h", $time, out_data);
        bad_verdicts++;
      end else begin
        head_verdict = verdict_q.pop_front();
        cmp_field("action", head_verdict.action, out_data.action);
        cmp_field("verdict", head_verdict.verdict, out_data.verdict);
        cmp_field("source_port", head_verdict.source_port, out_data.source_port);
        cmp_field("destination_port", head_verdict.destination_port,
                  out_data.destination_port);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    bit ok;
    if (tx_gaps && burst_left == 0) begin
      gap = $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    if (burst_left > 0)
      burst_left--;
    in_valid <= 1'b1;
    in_data <= {b, last};
    do begin
      @(negedge clk);
      ok = in_ready;
      @(posedge clk);
    end while (!ok);
    items_sent++;
    if (kept_len < KEPT_BYTES)
      kept_hdr[kept_len] = b;
    if (kept_len < l4f_pkg::COUNT_MAX)
      kept_len++;
    if (last) begin
      verdict_q.push_back(classify_frame());
      kept_len = 0;
    end
  endtask

  // random fill, then the header fields; ports go first so IHL and protocol win
  task automatic send_frame(input logic [15:0] etype, input logic [7:0] proto,
                            input logic [3:0] ihl, input logic [15:0] sp,
                            input logic [15:0] dp, input int len);
    int off;
    frame_buf.delete();
    repeat (len) frame_buf.push_back(8'($urandom));
    off = (etype == l4f_pkg::ETYPE_IPV6) ? l4f_pkg::POS_L4_V6 : l4f_pkg::POS_IHL + 4 * ihl;
    poke(off, sp[15:8]);
    poke(off + 1, sp[7:0]);
    poke(off + 2, dp[15:8]);
    poke(off + 3, dp[7:0]);
    poke(l4f_pkg::POS_ETYPE_HI, etype[15:8]);
    poke(l4f_pkg::POS_ETYPE_LO, etype[7:0]);
    if (etype == l4f_pkg::ETYPE_IPV6) begin
      poke(l4f_pkg::POS_PROTO6, proto);
    end else begin
      poke(l4f_pkg::POS_IHL, {4'($urandom), ihl});
      poke(l4f_pkg::POS_PROTO4, proto);
    end
    for (int i = 0; i < len; i++)
      send_byte(frame_buf[i], i == len - 1);
  endtask

  task automatic write_reg(input logic [l4f_pkg::CFG_IDX_W-1:0] idx,
                           input logic [l4f_pkg::CFG_DATA_W-1:0] val);
    bit ok;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do begin
      @(negedge clk);
      ok = cfg_ready;
      @(posedge clk);
    end while (!ok);
    case (idx)
      l4f_pkg::REG_ALLOW_ACTION: allow_act = val[7:0];
      l4f_pkg::REG_DENY_ACTION:  deny_act = val[7:0];
      l4f_pkg::REG_PORTS_FIRST:
        for (int k = 0; k < 4; k++) slot_port[k] = val[16*k +: 16];
      l4f_pkg::REG_PORTS_SECOND:
        for (int k = 0; k < 4; k++) slot_port[4 + k] = val[16*k +: 16];
      l4f_pkg::REG_PORTS_THIRD:
        for (int k = 0; k < 2; k++) slot_port[8 + k] = val[16*k +: 16];
      default: ;
    endcase
  endtask

  // unused upper data bits carry junk; stray adds a write past the register list
  task automatic load_settings(input logic [7:0] a, input logic [7:0] d,
                               input logic [63:0] p1, input logic [63:0] p2,
                               input logic [31:0] p3, input bit stray);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    write_reg(l4f_pkg::REG_ALLOW_ACTION, {junk[63:8], a});
    write_reg(l4f_pkg::REG_DENY_ACTION, {junk[63:8], d});
    write_reg(l4f_pkg::REG_PORTS_FIRST, p1);
    write_reg(l4f_pkg::REG_PORTS_SECOND, p2);
    write_reg(l4f_pkg::REG_PORTS_THIRD, {junk[63:32], p3});
    if (stray)
      write_reg(REG_UNUSED, '1);
    cfg_valid <= 1'b0;
  endtask

  // hold off input until every verdict is back, then let the pipe empty
  task automatic settle();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (verdict_q.size() != 0 && waited < 4000) begin
      @(posedge clk);
      waited++;
    end
    repeat (6) @(posedge clk);
  endtask

  task automatic test_parse_cases();
    send_frame(l4f_pkg::ETYPE_IPV4, l4f_pkg::PROTO_UDP, 4'd5, 16'd0, 16'd0, 1);
    send_frame(l4f_pkg::ETYPE_IPV4, l4f_pkg::PROTO_UDP, 4'd5, 16'd0, 16'd0, 13);
    send_frame(l4f_pkg::ETYPE_IPV4, l4f_pkg::PROTO_UDP, 4'd5, 16'd0, 16'd0, 14);
    send_frame(l4f_pkg::ETYPE_IPV4, l4f_pkg::PROTO_UDP, 4'd5, 16'd0, 16'd0, 33);
    send_frame(l4f_pkg::ETYPE_IPV4, l4f_pkg::PROTO_UDP, 4'd5, 16'd0, 16'd0, 41);
    send_frame(l4f_pkg::ETYPE_IPV4, l4f_pkg::PROTO_UDP, 4'd5, 16'd0, 16'd0, 42);
    send_frame(l4f_pkg::ETYPE_IPV4, l4f_pkg::PROTO_TCP, 4'd5, 16'd1234, 16'd80, 53);
    send_frame(l4f_pkg::ETYPE_IPV4, l4f_pkg::PROTO_TCP, 4'd5, 16'hFFFF, 16'd1, 54);
    send_frame(l4f_pkg::ETYPE_IPV4, l4f_pkg::PROTO_UDP, 4'd15, 16'd53, 16'hFFFF, 82);
    // IHL under 5: ports overlap the IP header
    send_frame(l4f_pkg::ETYPE_IPV4, l4f_pkg::PROTO_UDP, 4'd0, 16'h4500, 16'h0011, 34);
    send_frame(l4f_pkg::ETYPE_IPV4, l4f_pkg::PROTO_TCP, 4'd2, 16'd7, 16'd9,
               full_len(l4f_pkg::ETYPE_IPV4, l4f_pkg::PROTO_TCP, 4'd2));
    send_frame(l4f_pkg::ETYPE_IPV6, l4f_pkg::PROTO_UDP, 4'd5, 16'd0, 16'd0, 53);
    send_frame(l4f_pkg::ETYPE_IPV6, l4f_pkg::PROTO_UDP, 4'd5, 16'd1, 16'd2, 61);
    send_frame(l4f_pkg::ETYPE_IPV6, l4f_pkg::PROTO_UDP, 4'd5, 16'd443, 16'd0, 62);
    send_frame(l4f_pkg::ETYPE_IPV6, l4f_pkg::PROTO_TCP, 4'd5, 16'd22, 16'd8080, 74);
    send_frame(ETYPE_LLDP, l4f_pkg::PROTO_UDP, 4'd5, 16'd0, 16'd0, 20);
    send_frame(16'h0000, l4f_pkg::PROTO_TCP, 4'd5, 16'd0, 16'd0, 14);
    send_frame(16'hFFFF, l4f_pkg::PROTO_TCP, 4'd5, 16'd0, 16'd0, 20);
    send_frame(l4f_pkg::ETYPE_IPV4, PROTO_ICMP, 4'd5, 16'd0, 16'd0, 34);
    send_frame(l4f_pkg::ETYPE_IPV6, PROTO_ICMP6, 4'd5, 16'd0, 16'd0, 54);
    // long enough to stop the header store and saturate the count
    send_frame(l4f_pkg::ETYPE_IPV4, l4f_pkg::PROTO_UDP, 4'd5, 16'd5000, 16'd6000, 130);
  endtask

  task automatic test_register_extremes();
    settle();
    load_settings(8'd0, 8'd255, '1, '1, '1, 1'b0);
    send_frame(l4f_pkg::ETYPE_IPV4, l4f_pkg::PROTO_UDP, 4'd5, 16'hFFFF, 16'd1, 42);
    send_frame(l4f_pkg::ETYPE_IPV6, l4f_pkg::PROTO_TCP, 4'd5, 16'd0, 16'd0, 74);
    settle();
    load_settings(8'd255, 8'd0, {$urandom, $urandom}, {$urandom, $urandom}, $urandom, 1'b1);
    send_frame(l4f_pkg::ETYPE_IPV4, l4f_pkg::PROTO_TCP, 4'd5, slot_port[0],
               16'($urandom), 54);
    send_frame(l4f_pkg::ETYPE_IPV4, l4f_pkg::PROTO_UDP, 4'd5, 16'($urandom),
               slot_port[9], 42);
    send_frame(l4f_pkg::ETYPE_IPV6, l4f_pkg::PROTO_UDP, 4'd5, slot_port[4],
               16'($urandom), 62);
    send_frame(l4f_pkg::ETYPE_IPV6, l4f_pkg::PROTO_TCP, 4'd5, 16'($urandom),
               slot_port[8], 74);
    send_frame(l4f_pkg::ETYPE_IPV4, l4f_pkg::PROTO_UDP, 4'd5, 16'($urandom),
               16'($urandom), 42);
  endtask

  task automatic test_random_traffic();
    int          frames_sent;
    int          kind;
    int          len;
    logic [15:0] etype;
    logic [7:0]  proto;
    logic [3:0]  ihl;
    frames_sent = 0;
    while (items_sent < ITEMS_TARGET || frames_sent < 6) begin
      if (frames_sent % 3 == 0) begin
        settle();
        tx_gaps = ($urandom_range(0, 3) != 0);
        rx_stalls = ($urandom_range(0, 3) != 0);
        if (frames_sent == 3) begin
          tx_gaps = 1'b0;
          rx_stalls = 1'b0;
        end
        case ($urandom_range(0, 5))
          0: load_settings(8'd0, 8'd0, '0, '0, '0, 1'b0);
          1: load_settings(8'd255, 8'd255, '1, '1, '1, 1'b1);
          default: load_settings(rand_action(), rand_action(),
                                 {rand_slot(), rand_slot(), rand_slot(), rand_slot()},
                                 {rand_slot(), rand_slot(), rand_slot(), rand_slot()},
                                 {rand_slot(), rand_slot()}, $urandom_range(0, 1));
        endcase
      end
      kind = $urandom_range(0, 99);
      etype = ($urandom_range(0, 9) < 6) ? l4f_pkg::ETYPE_IPV4 : l4f_pkg::ETYPE_IPV6;
      proto = $urandom_range(0, 1) ? l4f_pkg::PROTO_TCP : l4f_pkg::PROTO_UDP;
      ihl = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'd5;
      if (kind < 10) begin
        do proto = 8'($urandom);
        while (proto == l4f_pkg::PROTO_TCP || proto == l4f_pkg::PROTO_UDP);
      end else if (kind < 18) begin
        do etype = 16'($urandom);
        while (etype == l4f_pkg::ETYPE_IPV4 || etype == l4f_pkg::ETYPE_IPV6);
      end
      len = full_len(etype, proto, ihl);
      if (kind >= 18 && kind < 32)
        len = $urandom_range(1, len - 1);
      else if (kind >= 32 && kind < 36)
        len += $urandom_range(40, 150);
      else
        len += $urandom_range(0, 12);
      send_frame(etype, proto, ihl, pick_port(), pick_port(), len);
      frames_sent++;
    end
  endtask

  initial begin
    allow_act = l4f_pkg::RST_ALLOW_ACTION;
    deny_act = l4f_pkg::RST_DENY_ACTION;
    for (int s = 0; s < l4f_pkg::MAX_PORT_SLOTS; s++)
      slot_port[s] = 16'd0;
    kept_len = 0;
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_parse_cases();
    test_register_extremes();
    test_random_traffic();
    settle();

    if (verdict_q.size() != 0) begin
      $display("%0t ns: verdicts expected 0 pending, got %0d", $time, verdict_q.size());
      bad_verdicts++;
    end
    if (bad_verdicts == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  initial begin
    #1_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
